@@ design/pfsa_pkg.sv @@
// Shared types and codes for the free page stack allocator.
`timescale 1ns / 1ps

package pfsa_pkg;

	// Request modes.
	localparam logic [1:0] MODE_ADD_REGION = 2'd0;
	localparam logic [1:0] MODE_ALLOC      = 2'd1;
	localparam logic [1:0] MODE_FREE       = 2'd2;

	// Result status codes.
	localparam logic [2:0] STAT_OK             = 3'd0;
	localparam logic [2:0] STAT_NO_PAGES       = 3'd1;
	localparam logic [2:0] STAT_MISALIGNED     = 3'd2;
	localparam logic [2:0] STAT_NONE_ALLOCATED = 3'd3;
	localparam logic [2:0] STAT_TABLE_FULL     = 3'd4;

	// Request word.
	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] region_base;
		logic [31:0] region_bytes;
		logic [31:0] page_address;
	} pfsa_req_t;

	// Response word.
	typedef struct packed {
		logic [31:0] alloc_address;
		logic [2:0]  status;
		logic [12:0] pages_available;
	} pfsa_rsp_t;

endpackage

@@ design/pfsa_table.sv @@
// Page address table: one write port and one registered read port.
`timescale 1ns / 1ps

module pfsa_table #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_idx,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_idx,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Synchronous write and read; read data is registered and appears the cycle after rd_en.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/pfsa_ctrl.sv @@
// Allocator sequencer: keeps the page counts and drives the table accesses.
`timescale 1ns / 1ps

module pfsa_ctrl import pfsa_pkg::*; #(
	parameter int TABLE_DEPTH = 4096,
	parameter int PAGE_SHIFT  = 12,
	parameter int ADDR_BITS   = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  pfsa_req_t                      req,
	output logic                           res_valid,
	input  logic                           res_ready,
	output pfsa_rsp_t                      res,
	output logic                           tbl_wr_en,
	output logic [$clog2(TABLE_DEPTH)-1:0] tbl_wr_idx,
	output logic [ADDR_BITS-1:0]           tbl_wr_data,
	output logic                           tbl_rd_en,
	output logic [$clog2(TABLE_DEPTH)-1:0] tbl_rd_idx,
	input  logic [ADDR_BITS-1:0]           tbl_rd_data
);

	localparam int IW   = $clog2(TABLE_DEPTH);
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int NW   = 33 - PAGE_SHIFT;
	localparam int CMPW = (NW > CW) ? NW : CW;

	typedef enum logic [1:0] {S_IDLE, S_FILL, S_READ, S_DONE} state_t;

	state_t              state_q;
	logic [CW-1:0]       total_q;
	logic [CW-1:0]       alloc_q;
	logic [CW-1:0]       fill_cnt_q;
	logic [ADDR_BITS-1:0] fill_addr_q;
	logic [31:0]         res_addr_q;
	logic [2:0]          res_status_q;

	logic                accept;
	logic [NW-1:0]       needed;
	logic [CMPW-1:0]     needed_w;
	logic [CMPW-1:0]     room_w;
	logic [CMPW-1:0]     fill_count;
	logic                misaligned;
	logic [CW-1:0]       alloc_dec;
	logic [ADDR_BITS-1:0] page_step;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);

	// Pages the region asks for, rounded up, against the room left in the table.
	assign needed     = NW'(req.region_bytes >> PAGE_SHIFT)
	                  + NW'(|req.region_bytes[PAGE_SHIFT-1:0]);
	assign needed_w   = CMPW'(needed);
	assign room_w     = CMPW'(CW'(TABLE_DEPTH) - total_q);
	assign fill_count = (needed_w < room_w) ? needed_w : room_w;

	assign misaligned = |req.page_address[PAGE_SHIFT-1:0];
	assign alloc_dec  = alloc_q - CW'(1);
	assign page_step  = ADDR_BITS'(1) << PAGE_SHIFT;

	// Table writes come from a region fill or from an accepted free.
	always_comb begin
		tbl_wr_en   = 1'b0;
		tbl_wr_idx  = total_q[IW-1:0];
		tbl_wr_data = fill_addr_q;
		if (state_q == S_FILL) begin
			tbl_wr_en = 1'b1;
		end else if (accept && req.mode == MODE_FREE && !misaligned && alloc_q != '0) begin
			tbl_wr_en   = 1'b1;
			tbl_wr_idx  = alloc_dec[IW-1:0];
			tbl_wr_data = ADDR_BITS'(req.page_address);
		end
	end

	// An allocation with a free entry left reads that entry.
	assign tbl_rd_en  = accept && req.mode == MODE_ALLOC && alloc_q < total_q;
	assign tbl_rd_idx = alloc_q[IW-1:0];

	// The result leaves straight from the read data, or from the held result.
	always_comb begin
		res_valid           = (state_q == S_READ) || (state_q == S_DONE);
		res.alloc_address   = res_addr_q;
		res.status          = res_status_q;
		res.pages_available = 13'(total_q - alloc_q);
		if (state_q == S_READ) begin
			res.alloc_address = 32'(tbl_rd_data);
			res.status        = STAT_OK;
		end
	end

	// Sequencer, page counts and held result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			total_q      <= '0;
			alloc_q      <= '0;
			fill_cnt_q   <= '0;
			fill_addr_q  <= '0;
			res_addr_q   <= '0;
			res_status_q <= STAT_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_addr_q   <= '0;
						res_status_q <= STAT_OK;
						state_q      <= S_DONE;
						unique case (req.mode)
							MODE_ADD_REGION: begin
								fill_cnt_q  <= CW'(fill_count);
								fill_addr_q <= ADDR_BITS'(req.region_base);
								if (needed_w > room_w) begin
									res_status_q <= STAT_TABLE_FULL;
								end
								if (fill_count != '0) begin
									state_q <= S_FILL;
								end
							end
							MODE_ALLOC: begin
								if (alloc_q < total_q) begin
									alloc_q <= alloc_q + CW'(1);
									state_q <= S_READ;
								end else begin
									res_status_q <= STAT_NO_PAGES;
								end
							end
							MODE_FREE: begin
								if (misaligned) begin
									res_status_q <= STAT_MISALIGNED;
								end else if (alloc_q == '0) begin
									res_status_q <= STAT_NONE_ALLOCATED;
								end else begin
									alloc_q <= alloc_dec;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_FILL: begin
					// One page appended per cycle.
					total_q     <= total_q + CW'(1);
					fill_addr_q <= fill_addr_q + page_step;
					fill_cnt_q  <= fill_cnt_q - CW'(1);
					if (fill_cnt_q == CW'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_READ: begin
					// Keep the read word in case the output side is busy.
					res_addr_q   <= 32'(tbl_rd_data);
					res_status_q <= STAT_OK;
					state_q      <= res_ready ? S_IDLE : S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/page_frame_stack_allocator.sv @@
// Free page stack allocator top level: sequencer, page table and output register.
// Alloc, free and unused modes hand their word to the output register from S_DONE, or an alloc
// with a page left from S_READ, where it takes the table read data; rsp_valid is registered.
// An add-region word first appends its pages in S_FILL, then waits in S_DONE for hand-off.
// A new word is accepted only once the previous one has been handed to the output register.
// Reset clears both page counts; table contents are left undefined.
`timescale 1ns / 1ps

module page_frame_stack_allocator import pfsa_pkg::*; #(
	parameter int TABLE_DEPTH = 4096,
	parameter int PAGE_SHIFT  = 12,
	parameter int ADDR_BITS   = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  pfsa_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output pfsa_rsp_t rsp
);

	localparam int IW = $clog2(TABLE_DEPTH);

	logic                 res_valid;
	logic                 res_ready;
	pfsa_rsp_t            res;
	logic                 tbl_wr_en;
	logic [IW-1:0]        tbl_wr_idx;
	logic [ADDR_BITS-1:0] tbl_wr_data;
	logic                 tbl_rd_en;
	logic [IW-1:0]        tbl_rd_idx;
	logic [ADDR_BITS-1:0] tbl_rd_data;
	logic                 rsp_valid_q;
	pfsa_rsp_t            rsp_q;

	pfsa_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.PAGE_SHIFT (PAGE_SHIFT),
		.ADDR_BITS  (ADDR_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.tbl_wr_en  (tbl_wr_en),
		.tbl_wr_idx (tbl_wr_idx),
		.tbl_wr_data(tbl_wr_data),
		.tbl_rd_en  (tbl_rd_en),
		.tbl_rd_idx (tbl_rd_idx),
		.tbl_rd_data(tbl_rd_data)
	);

	pfsa_table #(
		.DEPTH(TABLE_DEPTH),
		.WIDTH(ADDR_BITS)
	) u_table (
		.clk    (clk),
		.wr_en  (tbl_wr_en),
		.wr_idx (tbl_wr_idx),
		.wr_data(tbl_wr_data),
		.rd_en  (tbl_rd_en),
		.rd_idx (tbl_rd_idx),
		.rd_data(tbl_rd_data)
	);

	// The output register takes a new word when it is empty or being drained.
	assign res_ready = res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ dv/page_frame_stack_allocator_test.sv @@
// Self-checking testbench for the free page stack allocator.
`timescale 1ns / 1ps

module page_frame_stack_allocator_test;
	import pfsa_pkg::*;

	localparam int FRAME_SLOTS = 4096;
	localparam int PAGE_SHIFT = 12;
	localparam longint unsigned PAGE_BYTES = 64'd1 << PAGE_SHIFT;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 1730;
	localparam int IDLE_LIMIT = 20000;
	localparam int PRESSURE_AFTER = 300;
	localparam int PRESSURE_CYCLES = 300;

	// Mirror of the page pool: predicts one response word per request word.
	class page_pool_model;
		logic [31:0] frame_table [FRAME_SLOTS];
		int unsigned entered;
		int unsigned lent;
		int unsigned mismatches;
		pfsa_rsp_t rsp_due [$];

		function new();
			entered = 0;
			lent = 0;
			mismatches = 0;
		endfunction

		function int unsigned outstanding();
			return rsp_due.size();
		endfunction

		function void note_request(pfsa_req_t w);
			pfsa_rsp_t r;
			longint unsigned needed;
			longint unsigned room;
			longint unsigned count;
			r = '0;
			case (w.mode)
				MODE_ADD_REGION: begin
					// One entry per page step; the rest is dropped once the table is full.
					needed = (64'(w.region_bytes) + PAGE_BYTES - 1) >> PAGE_SHIFT;
					room = FRAME_SLOTS - entered;
					count = (needed < room) ? needed : room;
					for (int k = 0; k < count; k++) begin
						frame_table[entered] = w.region_base + (32'(k) << PAGE_SHIFT);
						entered++;
					end
					r.status = (needed > room) ? STAT_TABLE_FULL : STAT_OK;
				end
				MODE_ALLOC: begin
					if (lent >= entered) begin
						r.status = STAT_NO_PAGES;
					end else begin
						r.alloc_address = frame_table[lent];
						lent++;
					end
				end
				MODE_FREE: begin
					// Alignment is checked before the loan count.
					if (w.page_address[PAGE_SHIFT-1:0] != '0) begin
						r.status = STAT_MISALIGNED;
					end else if (lent == 0) begin
						r.status = STAT_NONE_ALLOCATED;
					end else begin
						lent--;
						frame_table[lent] = w.page_address;
					end
				end
				default: begin
				end
			endcase
			r.pages_available = 13'(entered - lent);
			rsp_due.push_back(r);
		endfunction

		function void check_response(pfsa_rsp_t got);
			pfsa_rsp_t want;
			if (rsp_due.size() == 0) begin
				$display("%0t: response word with none expected, got %h", $time, got);
				mismatches++;
				return;
			end
			want = rsp_due.pop_front();
			if (got.alloc_address !== want.alloc_address) begin
				$display("%0t: alloc_address expected %h, got %h", $time,
					want.alloc_address, got.alloc_address);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
				mismatches++;
			end
			if (got.pages_available !== want.pages_available) begin
				$display("%0t: pages_available expected %0d, got %0d", $time,
					want.pages_available, got.pages_available);
				mismatches++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	pfsa_req_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	pfsa_rsp_t rsp;

	page_pool_model pool;
	int unsigned rsp_seen = 0;
	bit steady_feed = 1'b0;

	page_frame_stack_allocator #(
		.TABLE_DEPTH(FRAME_SLOTS),
		.PAGE_SHIFT(PAGE_SHIFT),
		.ADDR_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 65) begin
			return 0;
		end
		if (p < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic pfsa_req_t word_of(logic [1:0] m, logic [31:0] base,
		logic [31:0] bytes, logic [31:0] addr);
		pfsa_req_t w;
		w.mode = m;
		w.region_base = base;
		w.region_bytes = bytes;
		w.page_address = addr;
		return w;
	endfunction

	// Random request word; drain leans toward allocs, otherwise toward frees.
	function automatic pfsa_req_t random_word(bit drain, bit wide);
		pfsa_req_t w;
		int pick;
		logic [31:0] a;
		w.region_base = $urandom();
		if (wide && $urandom_range(0, 1)) begin
			w.region_bytes = $urandom();
		end else begin
			w.region_bytes = $urandom_range(0, 5 << PAGE_SHIFT);
		end
		a = $urandom();
		if ($urandom_range(0, 9) < 8) begin
			a[PAGE_SHIFT-1:0] = '0;
		end
		w.page_address = a;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			w.mode = MODE_ADD_REGION;
		end else if (pick < 20) begin
			w.mode = MODE_UNUSED;
		end else if (pick < (drain ? 70 : 40)) begin
			w.mode = MODE_ALLOC;
		end else begin
			w.mode = MODE_FREE;
		end
		return w;
	endfunction

	// Offer one word from a falling edge and return at the falling edge after it is taken.
	task automatic send(pfsa_req_t w);
		int gap;
		gap = steady_feed ? 0 : pick_gap();
		repeat (gap) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (req_stall);
		pool.note_request(w);
		@(negedge clk);
	endtask

	// Response side: check every accepted word.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			pool.check_response(rsp);
			rsp_seen++;
		end
	end

	// Response stall: alternating run and stall stretches, plus one long hold-off.
	initial begin
		int left;
		bit holding;
		bit pressure_done;
		left = 0;
		holding = 1'b0;
		pressure_done = 1'b0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!pressure_done && rsp_seen >= PRESSURE_AFTER) begin
				pressure_done = 1'b1;
				rsp_stall <= 1'b1;
				holding = 1'b1;
				left = 0;
				repeat (PRESSURE_CYCLES - 1) @(negedge clk);
			end else if (left == 0) begin
				holding = !holding;
				if (holding) begin
					left = pick_gap();
					if (left == 0) begin
						left = 1;
					end
				end else if ($urandom_range(0, 9) == 0) begin
					left = $urandom_range(50, 150);
				end else begin
					left = $urandom_range(1, 8);
				end
				rsp_stall <= holding;
				left--;
			end else begin
				left--;
			end
		end
	end

	// Watchdog: too long without any word moving on either side.
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		int seg_left;
		bit drain;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		pool = new();
		seg_left = 0;
		drain = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty pool: alloc and free both refused, misaligned reported first.
		send(word_of(MODE_ALLOC, '0, '0, '0));
		send(word_of(MODE_FREE, '0, '0, 32'h0000_5000));
		send(word_of(MODE_FREE, '0, '0, 32'h0000_0801));
		send(word_of(MODE_UNUSED, 32'h1234_5678, 32'h9abc_def0, 32'h0fed_cba9));
		// Regions: empty, wrapping past the top, unaligned base, exact page.
		send(word_of(MODE_ADD_REGION, 32'h8000_0000, 32'h0, '0));
		send(word_of(MODE_ADD_REGION, 32'hffff_e000, 32'h0000_3001, '0));
		send(word_of(MODE_ADD_REGION, 32'h0001_2345, 32'h0000_0001, '0));
		send(word_of(MODE_ADD_REGION, 32'h4000_0000, 32'h0000_1000, '0));
		repeat (5) send(word_of(MODE_ALLOC, '0, '0, '0));
		// Frees: misaligned all-ones, a foreign page, page zero.
		send(word_of(MODE_FREE, '0, '0, 32'hffff_ffff));
		send(word_of(MODE_FREE, '0, '0, 32'habcd_e000));
		send(word_of(MODE_FREE, '0, '0, 32'h0000_0000));
		// Drain to out of pages.
		repeat (4) send(word_of(MODE_ALLOC, '0, '0, '0));
		send(word_of(MODE_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));

		// Random traffic in stretches of alloc-heavy or free-heavy words.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(20, 120);
				drain = $urandom_range(0, 1);
				steady_feed = ($urandom_range(0, 3) == 0);
			end
			seg_left--;
			if (n == RANDOM_WORDS / 2) begin
				// Fill the table exactly, then overflow it with a one-byte region.
				send(word_of(MODE_ADD_REGION, 32'hffff_f000,
					32'((FRAME_SLOTS - pool.entered) << PAGE_SHIFT), '0));
				send(word_of(MODE_ADD_REGION, 32'h0000_0000, 32'h0000_0001, '0));
			end
			send(random_word(drain, n >= RANDOM_WORDS / 2));
		end
		req_valid <= 1'b0;

		while (pool.outstanding() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (pool.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
